>>> hw/rtl/ppv_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ppv_pkg: shared types and helpers for the polyline point validator
// Sizes, verdict codes, controller/datapath interface structs and the
// orientation and bounding-box helpers used by the scan datapath.
// ---------------------------------------------------------------------------
package ppv_pkg;

  // store depth and coordinate size
  localparam int MAX_POINTS   = 16;
  localparam int COORD_BITS   = 8;
  localparam int CNT_BITS     = $clog2(MAX_POINTS + 1);
  localparam int IDX_BITS     = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int OUT_CNT_BITS = 5;

  // orientation arithmetic widths
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int ORI_BITS  = PROD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic signed [ORI_BITS-1:0]   ori_val_t;

  typedef enum logic [2:0] {
    V_ACCEPT = 3'd0,
    V_CLEAR  = 3'd1,
    V_DUP    = 3'd2,
    V_ONSEG  = 3'd3,
    V_CROSS  = 3'd4,
    V_FULL   = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_POS = 2'd1,
    ORI_NEG = 2'd2
  } ori_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, reset scan flags
    logic issue;   // read next stored vertex
    logic commit;  // resolve verdict, update store and result
  } ppv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic last_issue;
    logic pipe_busy;
  } ppv_sts_t;

  // signed cross product of (c-b) and (b-a), one multiply level and a subtract
  function automatic ori_val_t orient_val(input coord_t ax, ay, bx, by, cx, cy);
    logic signed [DIFF_BITS-1:0] d1, d2, d3, d4;
    logic signed [PROD_BITS-1:0] p1, p2;
    d1 = DIFF_BITS'(by) - DIFF_BITS'(ay);
    d2 = DIFF_BITS'(cx) - DIFF_BITS'(bx);
    d3 = DIFF_BITS'(bx) - DIFF_BITS'(ax);
    d4 = DIFF_BITS'(cy) - DIFF_BITS'(by);
    p1 = PROD_BITS'(d1) * PROD_BITS'(d2);
    p2 = PROD_BITS'(d3) * PROD_BITS'(d4);
    return ORI_BITS'(p1) - ORI_BITS'(p2);
  endfunction

  function automatic ori_t orient_cls(input ori_val_t v);
    if (v == '0) return ORI_COL;
    else if (v > 0) return ORI_POS;
    else return ORI_NEG;
  endfunction

  // point p within the bounding box of segment a-b
  function automatic logic in_box(input coord_t ax, ay, bx, by, px, py);
    coord_t lx, hx, ly, hy;
    lx = (ax < bx) ? ax : bx;
    hx = (ax < bx) ? bx : ax;
    ly = (ay < by) ? ay : by;
    hy = (ay < by) ? by : ay;
    return (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ppv_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ppv_ctrl: sequencing controller
// Handles both handshakes, steps the vertex scan and commits one result
// per request into the output register.
// ---------------------------------------------------------------------------
module ppv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_op,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ppv_pkg::ppv_sts_t sts,
  output ppv_pkg::ppv_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ISSUE  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // clears, full store and empty store need no scan
          if (!in_op || sts.full || sts.empty) state_nxt = S_DECIDE;
          else state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result slot occupancy
  always_comb begin
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hw/rtl/ppv_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ppv_datapath: vertex store and scan pipeline
// Holds the polyline, reads one vertex a cycle, forms orientation terms in
// a registered stage and folds duplicate, on-segment and crossing flags.
// ---------------------------------------------------------------------------
module ppv_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ppv_pkg::ppv_cmd_t cmd,
  output ppv_pkg::ppv_sts_t      sts,
  input  wire logic              in_op,
  input  wire logic [7:0]        in_cand_x,
  input  wire logic [7:0]        in_cand_y,
  output logic                   out_accepted,
  output logic [2:0]             out_verdict,
  output logic [4:0]             out_point_count
);

  localparam int CB = ppv_pkg::CNT_BITS;
  localparam int IB = ppv_pkg::IDX_BITS;

  // store
  ppv_pkg::coord_t mem_x_r [ppv_pkg::MAX_POINTS];
  ppv_pkg::coord_t mem_y_r [ppv_pkg::MAX_POINTS];
  ppv_pkg::cnt_t   count_r, count_nxt;
  ppv_pkg::coord_t last_x_r, last_y_r;

  // request
  logic            op_r;
  ppv_pkg::coord_t cand_x_r, cand_y_r;
  ppv_pkg::cnt_t   addr_r;

  // read stage
  logic            rd_vld_r;
  ppv_pkg::cnt_t   rd_idx_r;
  ppv_pkg::coord_t rd_x_r, rd_y_r;
  ppv_pkg::coord_t pv_x_r, pv_y_r;

  // orientation stage
  logic              o_vld_r;
  ppv_pkg::cnt_t     o_idx_r;
  logic              dup_r;
  ppv_pkg::ori_val_t ov_abc_r, ov_abl_r, ov_lca_r, ov_lcb_r;
  logic              bx_abc_r, bx_abl_r, bx_lca_r, bx_lcb_r;

  // flags
  logic f_dup_r, f_onseg_r, f_cross_r;

  // result
  logic               res_acc_r;
  ppv_pkg::verdict_t  res_verdict_r, verdict;

  logic full, is_full_accept;
  logic seg_ok, cross_ok, hit_onseg, hit_cross;
  ppv_pkg::ori_t o1, o2, o3, o4;

  assign full = (count_r >= CB'(ppv_pkg::MAX_POINTS));

  // status
  assign sts.full       = full;
  assign sts.empty      = (count_r == '0);
  assign sts.last_issue = ((addr_r + CB'(1)) == count_r);
  assign sts.pipe_busy  = rd_vld_r | o_vld_r;

  // verdict priority: clear, full, duplicate, on segment, crossing
  always_comb begin
    if (!op_r) verdict = ppv_pkg::V_CLEAR;
    else if (full) verdict = ppv_pkg::V_FULL;
    else if (f_dup_r) verdict = ppv_pkg::V_DUP;
    else if (f_onseg_r) verdict = ppv_pkg::V_ONSEG;
    else if (f_cross_r) verdict = ppv_pkg::V_CROSS;
    else verdict = ppv_pkg::V_ACCEPT;
  end

  assign is_full_accept = (verdict == ppv_pkg::V_ACCEPT);

  always_comb begin
    count_nxt = count_r;
    if (cmd.commit) begin
      if (!op_r) count_nxt = '0;
      else if (is_full_accept) count_nxt = count_r + CB'(1);
    end
  end

  // segment tests on the orientation stage: segment is vertex k-1 to k
  assign o1 = ppv_pkg::orient_cls(ov_abl_r);
  assign o2 = ppv_pkg::orient_cls(ov_abc_r);
  assign o3 = ppv_pkg::orient_cls(ov_lca_r);
  assign o4 = ppv_pkg::orient_cls(ov_lcb_r);

  assign seg_ok    = (o_idx_r != '0);
  // non-adjacent segments only, once three vertices are stored
  assign cross_ok  = seg_ok && (count_r >= CB'(3)) && ((o_idx_r + CB'(1)) < count_r);
  assign hit_onseg = (o2 == ppv_pkg::ORI_COL) && bx_abc_r;
  assign hit_cross = ((o1 != o2) && (o3 != o4)) ||
                     ((o1 == ppv_pkg::ORI_COL) && bx_abl_r) ||
                     ((o2 == ppv_pkg::ORI_COL) && bx_abc_r) ||
                     ((o3 == ppv_pkg::ORI_COL) && bx_lca_r) ||
                     ((o4 == ppv_pkg::ORI_COL) && bx_lcb_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_vld_r <= cmd.issue;
      o_vld_r  <= rd_vld_r;
    end
  end

  // store writes on append
  always_ff @(posedge clk) begin
    if (cmd.commit && op_r && is_full_accept) begin
      mem_x_r[count_r[IB-1:0]] <= cand_x_r;
      mem_y_r[count_r[IB-1:0]] <= cand_y_r;
      last_x_r <= cand_x_r;
      last_y_r <= cand_y_r;
    end
  end

  // request capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      cand_x_r <= ppv_pkg::coord_t'(in_cand_x[ppv_pkg::COORD_BITS-1:0]);
      cand_y_r <= ppv_pkg::coord_t'(in_cand_y[ppv_pkg::COORD_BITS-1:0]);
      addr_r   <= '0;
    end else if (cmd.issue) begin
      addr_r   <= addr_r + CB'(1);
    end
  end

  // registered store read
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_x_r   <= mem_x_r[addr_r[IB-1:0]];
      rd_y_r   <= mem_y_r[addr_r[IB-1:0]];
      rd_idx_r <= addr_r;
    end
  end

  // orientation stage; the l-c orientation of vertex k-1 is reused
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      pv_x_r   <= rd_x_r;
      pv_y_r   <= rd_y_r;
      o_idx_r  <= rd_idx_r;
      dup_r    <= (rd_x_r == cand_x_r) && (rd_y_r == cand_y_r);
      ov_abc_r <= ppv_pkg::orient_val(pv_x_r, pv_y_r, rd_x_r, rd_y_r, cand_x_r, cand_y_r);
      ov_abl_r <= ppv_pkg::orient_val(pv_x_r, pv_y_r, rd_x_r, rd_y_r, last_x_r, last_y_r);
      ov_lcb_r <= ppv_pkg::orient_val(last_x_r, last_y_r, cand_x_r, cand_y_r, rd_x_r, rd_y_r);
      ov_lca_r <= ov_lcb_r;
      bx_abc_r <= ppv_pkg::in_box(pv_x_r, pv_y_r, rd_x_r, rd_y_r, cand_x_r, cand_y_r);
      bx_abl_r <= ppv_pkg::in_box(pv_x_r, pv_y_r, rd_x_r, rd_y_r, last_x_r, last_y_r);
      bx_lcb_r <= ppv_pkg::in_box(last_x_r, last_y_r, cand_x_r, cand_y_r, rd_x_r, rd_y_r);
      bx_lca_r <= bx_lcb_r;
    end
  end

  // flag accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_dup_r   <= 1'b0;
      f_onseg_r <= 1'b0;
      f_cross_r <= 1'b0;
    end else if (o_vld_r) begin
      f_dup_r   <= f_dup_r | dup_r;
      f_onseg_r <= f_onseg_r | (seg_ok && hit_onseg);
      f_cross_r <= f_cross_r | (cross_ok && hit_cross);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_acc_r     <= is_full_accept;
      res_verdict_r <= verdict;
    end
  end

  assign out_accepted    = res_acc_r;
  assign out_verdict     = res_verdict_r;
  assign out_point_count = ppv_pkg::OUT_CNT_BITS'(count_r);

endmodule
`default_nettype wire

>>> hw/rtl/polyline_point_validator.sv
`default_nettype none
// An offer against n stored vertices (0 < n < full) walks the single store read port over
// the vertices one per cycle, drains the two-stage test pipeline and then commits its result
// once the output slot is free; clears, empty-store and full-store offers skip the scan.
// A new request is taken only after the result of the last one has been committed.
// Reset (rst_n, synchronous, active low) empties the polyline and drops any pending result;
// stored coordinates are not cleared and are only read below the vertex count.
// ---------------------------------------------------------------------------
// polyline_point_validator: incremental polyline builder
// Clears the polyline or tests a candidate point against the stored
// vertices and segments and appends it when it is clean.
// ---------------------------------------------------------------------------
module polyline_point_validator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_op,
  input  wire logic [7:0] in_cand_x,
  input  wire logic [7:0] in_cand_y,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_accepted,
  output logic [2:0]      out_verdict,
  output logic [4:0]      out_point_count
);

  ppv_pkg::ppv_cmd_t cmd;
  ppv_pkg::ppv_sts_t sts;

  // sequencing
  ppv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store and tests
  ppv_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_cand_x       (in_cand_x),
    .in_cand_y       (in_cand_y),
    .out_accepted    (out_accepted),
    .out_verdict     (out_verdict),
    .out_point_count (out_point_count)
  );

endmodule
`default_nettype wire
